>>> sv/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// Types and constants shared by the sequence number duplicate cache and its
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

    localparam int SRC_W    = 32;
    localparam int SEQ_W    = 16;
    localparam int STAMP_W  = 48;
    localparam int TMO_W    = 16;
    localparam int COUNT_W  = 7;
    localparam int MSEC_W   = 10;
    localparam int SPAN_W   = TMO_W + MSEC_W;
    localparam int WORD_W   = SRC_W + SEQ_W + STAMP_W;

    // entry word layout
    localparam int STAMP_LSB = 0;
    localparam int SEQ_LSB   = STAMP_W;
    localparam int SRC_LSB   = STAMP_W + SEQ_W;

    localparam logic [MSEC_W-1:0]  MS_PER_SEC    = MSEC_W'(1000);
    localparam logic [TMO_W-1:0]   TIMEOUT_RESET = TMO_W'(30);
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

    localparam logic REQ_CHECK = 1'b0;
    localparam logic REQ_SWEEP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> sv/seqnum_duplicate_cache.sv
// ----------------------------------------------------------------------------
// seqnum_duplicate_cache
// Duplicate filter over a bounded table of sources, each holding the last
// accepted sequence number and the time of its last update.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and its result appears
// on the o_ ports for one cycle with o_done high; the receiver cannot stall,
// so the result must be captured in that cycle. Every item, check or sweep,
// keeps busy high through a walk of every slot and a finish state: the table
// sits in one synchronous memory with a single read port, and the walk takes
// one read per cycle into a read register, then the finish state decides and
// writes back. The next item can be taken in the cycle its result is shown.
// Valid bits are all cleared at reset, so no clearing pass is needed. Timeout
// writes are taken at any time but belong between items.
// ----------------------------------------------------------------------------
`default_nettype none

module seqnum_duplicate_cache
    import sdc_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    input  wire                 start,
    output logic                busy,
    input  wire                 i_req_type,
    input  wire [SRC_W-1:0]     i_src_id,
    input  wire [SEQ_W-1:0]     i_seq_num,
    input  wire [STAMP_W-1:0]   i_now_ms,

    output logic                o_done,
    output logic                o_is_new,
    output logic                o_stored,
    output logic [COUNT_W-1:0]  o_removed_count,

    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [TMO_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    t_state r_state, n_state;

    logic [TMO_W-1:0]   r_timeout;
    logic               r_req;
    logic [SRC_W-1:0]   r_src;
    logic [SEQ_W-1:0]   r_seq;
    logic [STAMP_W-1:0] r_now;
    logic [SPAN_W-1:0]  r_span;

    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_rd_on;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic [WORD_W-1:0]  r_rd_data;
    logic               r_rd_valid;

    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [SEQ_W-1:0]   r_hit_seq;
    logic               r_free;
    logic [IDX_W-1:0]   r_free_idx;
    logic [COUNT_W-1:0] r_count;

    logic               r_valid [ENTRIES];
    logic [WORD_W-1:0]  r_mem   [ENTRIES];

    logic               r_done;
    logic               r_is_new;
    logic               r_stored;
    logic [COUNT_W-1:0] r_removed;

    logic               accept;
    logic               scan_last;
    logic               cmp_valid;
    logic               src_match;
    logic [STAMP_W:0]   expiry;
    logic               expired;
    logic [SEQ_W-1:0]   seq_diff;
    logic               newer;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic               set_valid;
    logic               fin_new;
    logic               fin_stored;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign scan_last = r_cmp_vld && (r_cmp_idx == LAST_IDX);
    assign cmp_valid = r_rd_valid;
    assign src_match = (r_rd_data[SRC_LSB +: SRC_W] == r_src);
    assign expiry    = {1'b0, r_rd_data[STAMP_LSB +: STAMP_W]}
                     + (STAMP_W + 1)'(r_span);
    assign expired   = expiry < {1'b0, r_now};

    // serial compare: newer when distance lies in 1 .. half range minus one
    assign seq_diff  = r_seq - r_hit_seq;
    assign newer     = (seq_diff != '0) && !seq_diff[SEQ_W-1];

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        wr_en      = 1'b0;
        wr_idx     = r_hit_idx;
        set_valid  = 1'b0;
        fin_new    = 1'b0;
        fin_stored = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
                if (r_req == REQ_CHECK) begin
                    priority if (r_hit) begin
                        fin_new    = newer;
                        fin_stored = newer;
                        wr_en      = newer;
                        wr_idx     = r_hit_idx;
                    end else if (r_free) begin
                        fin_new    = 1'b1;
                        fin_stored = 1'b1;
                        wr_en      = 1'b1;
                        wr_idx     = r_free_idx;
                        set_valid  = 1'b1;
                    end else begin
                        fin_new    = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req_type;
            r_src  <= i_src_id;
            r_seq  <= i_seq_num;
            r_now  <= i_now_ms;
            r_span <= SPAN_W'(r_timeout) * SPAN_W'(MS_PER_SEC);
        end
    end

    // slot walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_on   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_rd_idx  <= '0;
            r_cmp_idx <= '0;
        end else if (accept) begin
            r_rd_on   <= 1'b1;
            r_cmp_vld <= 1'b0;
            r_rd_idx  <= '0;
        end else begin
            r_cmp_vld <= r_rd_on;
            r_cmp_idx <= r_rd_idx;
            if (r_rd_on) begin
                if (r_rd_idx == LAST_IDX) begin
                    r_rd_on <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + IDX_W'(1);
                end
            end
        end
    end

    // lookup and sweep results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_count <= '0;
        end else if (accept) begin
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_count <= '0;
        end else if (r_cmp_vld) begin
            if (r_req == REQ_SWEEP) begin
                if (cmp_valid && expired && (r_count != COUNT_MAX)) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end else begin
                if (cmp_valid && src_match && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                    r_hit_seq <= r_rd_data[SEQ_LSB +: SEQ_W];
                end
                if (!cmp_valid && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (r_cmp_vld && (r_req == REQ_SWEEP) && cmp_valid && expired) begin
                r_valid[r_cmp_idx] <= 1'b0;
            end
            if (set_valid) begin
                r_valid[wr_idx] <= 1'b1;
            end
        end
    end

    // entry memory, write back only after the walk ends
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= {r_src, r_seq, r_now};
        end
        r_rd_data  <= r_mem[r_rd_idx];
        r_rd_valid <= r_valid[r_rd_idx];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == ST_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH) begin
            r_is_new  <= fin_new;
            r_stored  <= fin_stored;
            r_removed <= (r_req == REQ_SWEEP) ? r_count : '0;
        end
    end

    assign o_done          = r_done;
    assign o_is_new        = r_is_new;
    assign o_stored        = r_stored;
    assign o_removed_count = r_removed;

endmodule

`default_nettype wire

>>> sv/sdc_checker.sv
// ----------------------------------------------------------------------------
// sdc_checker
// Port level checks for the sequence number duplicate cache.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_checker
    import sdc_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 start,
    input wire                 busy,
    input wire                 o_done,
    input wire                 o_is_new,
    input wire                 o_stored,
    input wire [COUNT_W-1:0]   o_removed_count
);

    // an accepted item holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after item");

    // a result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without item in flight");

    // one cycle strobe per item
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // an entry is only stored for a new packet
    a_stored_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_stored) |-> o_is_new)
        else $error("stored without new");

    // a sweep that removed entries reports no check flags
    a_sweep_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_removed_count != '0)) |-> (!o_is_new && !o_stored))
        else $error("sweep result carries check flags");

endmodule

bind seqnum_duplicate_cache sdc_checker u_sdc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_is_new        (o_is_new),
    .o_stored        (o_stored),
    .o_removed_count (o_removed_count)
);

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sequence number duplicate cache.
// ----------------------------------------------------------------------------
// Drives check and sweep items through the start/busy port with random gaps.
// Each accepted item is run through a behavioural copy of the source table.
// That copy holds the serial number window, the lowest-free-slot insert, the
// full-table case and the unwrapped timeout sum. The expected result is
// queued, and every o_done cycle is compared field by field with the oldest
// entry. The timeout register is rewritten between phases once the block has
// drained. The phases run from short to maximum timeouts and from a few
// sources to more sources than the table holds.
// ----------------------------------------------------------------------------
module tb_top;
    import sdc_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic               req;
        logic [SRC_W-1:0]   src;
        logic [SEQ_W-1:0]   seq;
        logic [STAMP_W-1:0] now;
    } cache_req_t;

    typedef struct packed {
        logic               is_new;
        logic               stored;
        logic [COUNT_W-1:0] removed;
    } cache_res_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_req_type;
    logic [SRC_W-1:0]   i_src_id;
    logic [SEQ_W-1:0]   i_seq_num;
    logic [STAMP_W-1:0] i_now_ms;
    logic               o_done;
    logic               o_is_new;
    logic               o_stored;
    logic [COUNT_W-1:0] o_removed_count;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [TMO_W-1:0]   i_cfg_data;

    // behavioural copy of the source table
    logic               tbl_valid [ENTRIES];
    logic [SRC_W-1:0]   tbl_src   [ENTRIES];
    logic [SEQ_W-1:0]   tbl_seq   [ENTRIES];
    logic [STAMP_W-1:0] tbl_stamp [ENTRIES];
    logic [TMO_W-1:0]   tbl_timeout;

    cache_res_t         expected_q [$];
    logic [SRC_W-1:0]   src_pool [128];
    logic [STAMP_W-1:0] clock_ms;
    int unsigned        fail_count = 0;
    int unsigned        stall_cycles = 0;
    int                 burst_left = 0;
    bit                 gapless;

    seqnum_duplicate_cache #(
        .ENTRIES (ENTRIES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_src_id        (i_src_id),
        .i_seq_num       (i_seq_num),
        .i_now_ms        (i_now_ms),
        .o_done          (o_done),
        .o_is_new        (o_is_new),
        .o_stored        (o_stored),
        .o_removed_count (o_removed_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [STAMP_W-1:0] rand_stamp();
        return STAMP_W'({$urandom, $urandom});
    endfunction

    function automatic cache_res_t cache_apply(input cache_req_t r);
        cache_res_t         res;
        logic [SPAN_W-1:0]  span;
        logic [STAMP_W:0]   expiry;
        logic [SEQ_W-1:0]   seq_gap;
        int                 hit;
        int                 free_slot;
        res = '0;
        hit = -1;
        free_slot = -1;
        if (r.req == REQ_SWEEP) begin
            span = SPAN_W'(tbl_timeout) * SPAN_W'(MS_PER_SEC);
            for (int i = 0; i < ENTRIES; i++) begin
                expiry = {1'b0, tbl_stamp[i]} + (STAMP_W + 1)'(span);
                if (tbl_valid[i] && expiry < {1'b0, r.now}) begin
                    tbl_valid[i] = 1'b0;
                    if (res.removed != COUNT_MAX) res.removed++;
                end
            end
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (tbl_valid[i]) begin
                    if (hit < 0 && tbl_src[i] == r.src) hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit >= 0) begin
                // newer only inside the forward half of the serial window
                seq_gap = r.seq - tbl_seq[hit];
                if (seq_gap != '0 && !seq_gap[SEQ_W-1]) begin
                    tbl_seq[hit]   = r.seq;
                    tbl_stamp[hit] = r.now;
                    res.is_new     = 1'b1;
                    res.stored     = 1'b1;
                end
            end else if (free_slot >= 0) begin
                tbl_valid[free_slot] = 1'b1;
                tbl_src[free_slot]   = r.src;
                tbl_seq[free_slot]   = r.seq;
                tbl_stamp[free_slot] = r.now;
                res.is_new           = 1'b1;
                res.stored           = 1'b1;
            end else begin
                res.is_new = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic report_field(input string name, input logic [COUNT_W-1:0] exp_v,
                                input logic [COUNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        cache_res_t exp_r;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h %0h %0h",
                         $time, o_is_new, o_stored, o_removed_count);
                fail_count++;
            end else begin
                exp_r = expected_q.pop_front();
                report_field("is_new", exp_r.is_new, o_is_new);
                report_field("stored", exp_r.stored, o_stored);
                report_field("removed_count", exp_r.removed, o_removed_count);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic wait_drained();
        if (expected_q.size() != 0) begin
            start <= 1'b0;
            while (expected_q.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic send_item(input cache_req_t r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(8, 40);
            gapless    = ($urandom_range(0, 2) == 0);
        end
        burst_left--;
        gap = gapless ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            start <= 1'b0;
            // sometimes place the gap after the block has gone idle
            if ($urandom_range(0, 1) == 1) begin
                do @(posedge i_clk); while (busy !== 1'b0);
            end
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req_type <= r.req;
        i_src_id   <= r.src;
        i_seq_num  <= r.seq;
        i_now_ms   <= r.now;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_q.push_back(cache_apply(r));
    endtask

    task automatic send_check(input logic [SRC_W-1:0] src, input logic [SEQ_W-1:0] seq,
                              input logic [STAMP_W-1:0] now);
        send_item('{req: REQ_CHECK, src: src, seq: seq, now: now});
    endtask

    task automatic send_sweep(input logic [STAMP_W-1:0] now);
        send_item('{req: REQ_SWEEP, src: $urandom, seq: SEQ_W'($urandom), now: now});
    endtask

    task automatic set_timeout(input logic [TMO_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tbl_timeout = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(input int pool_size, input int count, input int step_max);
        cache_req_t       r;
        int               k;
        int               n;
        int               hit;
        logic [SEQ_W-1:0] base;
        for (k = 0; k < pool_size; k++) src_pool[k] = $urandom;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 39) == 0) wait_drained();
            clock_ms += STAMP_W'($urandom_range(0, step_max));
            r.now = clock_ms;
            r.src = $urandom;
            r.seq = SEQ_W'($urandom);
            if ($urandom_range(0, 7) == 0) begin
                r.req = REQ_SWEEP;
            end else begin
                r.req = REQ_CHECK;
                if ($urandom_range(0, 49) == 0) r.now = rand_stamp();
                r.src = src_pool[$urandom_range(0, pool_size - 1)];
                hit = -1;
                for (k = 0; k < ENTRIES; k++) begin
                    if (hit < 0 && tbl_valid[k] && tbl_src[k] == r.src) hit = k;
                end
                base = (hit >= 0) ? tbl_seq[hit] : SEQ_W'($urandom);
                case ($urandom_range(0, 9))
                    0: r.seq = base;
                    1: r.seq = base + 16'h0001;
                    2: r.seq = base + 16'h7fff;
                    3: r.seq = base + 16'h8000;
                    4: r.seq = base + 16'h8001;
                    5: r.seq = base - 16'h0001;
                    6: ;
                    default: r.seq = base + SEQ_W'($urandom_range(2, 300));
                endcase
            end
            send_item(r);
        end
    endtask

    task automatic test_serial_window();
        send_check('0, 16'h0000, 48'd0);
        send_check('0, 16'h0000, 48'd10);
        send_check('0, 16'h0001, 48'd20);
        send_check('0, 16'h8001, 48'd30);
        send_check('0, 16'h8000, 48'd40);
        send_check('0, 16'h0000, 48'd50);
        send_check('0, 16'hffff, 48'd60);
        send_check('0, 16'h0000, 48'd100);
        send_check('1, '1, '1);
        send_check('1, 16'h0000, '1);
        send_check(32'h1234_5678, 16'h8000, 48'd50);
    endtask

    task automatic test_sweep_boundary();
        send_sweep(48'd0);
        send_sweep(48'd30100);
        send_sweep(48'd30101);
        send_sweep('1);
        send_check('0, 16'h0005, 48'd200);
        send_check('0, 16'h0005, 48'd200);
        set_timeout('0);
        send_check(32'ha5a5_a5a5, 16'h5a5a, 48'd1000);
        send_sweep(48'd1000);
        send_sweep(48'd1001);
        set_timeout('1);
        send_check(32'h0000_0001, 16'h0001, 48'd0);
        send_sweep(48'd65535000);
        send_sweep(48'd65535001);
        send_sweep('1);
    endtask

    task automatic test_light_traffic();
        set_timeout(TIMEOUT_RESET);
        clock_ms = 48'd500000;
        run_traffic(12, 300, 2000);
    endtask

    task automatic test_table_full();
        set_timeout('1);
        clock_ms = rand_stamp();
        run_traffic(96, 400, 1000);
    endtask

    task automatic test_short_timeout();
        set_timeout('0);
        run_traffic(20, 250, 3);
        set_timeout(16'd1);
        run_traffic(70, 250, 300);
    endtask

    task automatic test_random_timeout();
        int tmo;
        tmo = $urandom_range(2, 300);
        set_timeout(TMO_W'(tmo));
        run_traffic(40, 250, tmo * 100 + 10);
        set_timeout(TMO_W'($urandom));
        run_traffic(8, 100, 1000);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req_type  <= REQ_CHECK;
        i_src_id    <= '0;
        i_seq_num   <= '0;
        i_now_ms    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tbl_timeout = TIMEOUT_RESET;
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
        clock_ms = '0;

        test_serial_window();
        test_sweep_boundary();
        test_light_traffic();
        test_table_full();
        test_short_timeout();
        test_random_timeout();

        wait_drained();
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
